// ----- rtl/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// shared types, constants and the deletion table of the thinning subpass core
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

   localparam int DIR_W   = 2;
   localparam int WIDTH_W = 11;
   localparam int CNT_W   = 21;
   localparam int MAP_W   = 9;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // csr register indexes
   localparam logic CSR_DIRECTION   = 1'b0;
   localparam logic CSR_IMAGE_WIDTH = 1'b1;

   localparam logic [DIR_W-1:0]   DIRECTION_RESET = '0;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET     = 11'd1024;

   // neighbor that must be background: north, south, west, east
   localparam logic [MAP_W-1:0] DIR_MASK [4] = '{9'o200, 9'o002, 9'o040, 9'o010};

   // keeps the two older columns of the window when it shifts left
   localparam logic [MAP_W-1:0] SHIFT_MASK = 9'o666;

   // deletion table, entry 0 leftmost
   localparam logic [0:511] DEL_TABLE = {
      32'h0000_1373, 32'h0000_3B33, 32'h0000_00F3, 32'h0000_0033,
      32'h0000_00F3, 32'h0000_BBFF, 32'h0000_80F3, 32'h0000_BBFF,
      32'h0000_0000, 32'h0000_BB33, 32'h0000_0000, 32'h0000_0033,
      32'h0000_80F3, 32'h0000_BBFF, 32'h0000_80F3, 32'h0000_BBFF
   };

   // what the scan position says about one accepted beat
   typedef struct packed {
      logic              bot;        // effective pixel of the new bottom row
      logic              in_row;     // real column, touches the line store
      logic              first_col;  // column zero, window restarts
      logic              has_rsp;    // beat yields a result
      logic              last;       // result for the bottom-right pixel
      logic              frame_end;  // final beat of the padding row
      logic              mid_ok;     // middle row lies inside the image
      logic              top_ok;     // top row lies inside the image
      logic [ADDR_W-1:0] addr;       // line store column
   } scan_info_type;

endpackage

`default_nettype wire

// ----- rtl/binary_thinning_subpass_core.sv -----
// ----------------------------------------------------------------------------
// binary_thinning_subpass_core
// one directional subpass of neighborhood-map thinning on a raster stream
// ----------------------------------------------------------------------------
//
//  channel  ports                                   direction
//  req      req_valid req_stall req_pixel req_pad   in, one pixel beat
//  rsp      rsp_valid rsp_stall rsp_pixel_out ...   out, one result beat
//  csr      csr_write csr_index csr_data            in, register write
//
//  one beat per clock sustained unless the line store clear or rsp_stall
//  holds the flow; a beat is registered in the window stage (line store
//  read), then sits in the result register; after reset the line store is
//  swept clear over all MAX_WIDTH (1024) columns, req_stall stays high
//  meanwhile; csr writes are taken at any time; req_stall rises only during
//  that clear or when the window stage is full and the result register holds
//  a beat that rsp_stall keeps; results lag the input by one row and one pixel
// ----------------------------------------------------------------------------
`default_nettype none

module binary_thinning_subpass_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // pixel input
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_pixel,
   input  wire logic                           req_pad,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_pixel_out,
   output logic                                rsp_deleted,
   output logic                                rsp_last,
   output logic      [bts_pkg::CNT_W-1:0]      rsp_deletion_count,
   // register writes
   input  wire logic                           csr_write,
   input  wire logic                           csr_index,
   input  wire logic [bts_pkg::WIDTH_W-1:0]    csr_data
);

   // configuration registers
   logic [bts_pkg::DIR_W-1:0]   direction_ff, direction_in;
   logic [bts_pkg::WIDTH_W-1:0] width_ff, width_in;

   // window stage
   logic                   s1_valid_ff, s1_valid_in;
   bts_pkg::scan_info_type s1_info_ff;
   bts_pkg::scan_info_type scan_info;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_pixel_ff, rsp_deleted_ff, rsp_last_ff;
   logic [bts_pkg::CNT_W-1:0] rsp_count_ff;

   logic                      accept;
   logic                      advance;
   logic                      clr_busy;
   logic [1:0]                rd_data;
   logic [1:0]                wr_data;
   logic                      dec_pixel, dec_deleted;
   logic [bts_pkg::CNT_W-1:0] dec_count;

   // handshake: the window stage moves on whenever the result register
   // is empty or being emptied, result or not
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_busy || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   // csr writes
   always_comb begin
      direction_in = direction_ff;
      width_in     = width_ff;
      if (csr_write) begin
         case (csr_index)
            bts_pkg::CSR_DIRECTION: begin
               direction_in = csr_data[bts_pkg::DIR_W-1:0];
            end
            bts_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_data;
            end
            default: begin
               direction_in = direction_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= bts_pkg::DIRECTION_RESET;
         width_ff     <= bts_pkg::WIDTH_RESET;
      end else begin
         direction_ff <= direction_in;
         width_ff     <= width_in;
      end
   end

   // raster position and per-beat flags
   bts_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_pixel   (req_pixel),
      .req_pad     (req_pad),
      .image_width (width_ff),
      .info        (scan_info)
   );

   // line store: read when the beat enters, written back when it leaves
   // the window stage; consecutive real columns never share an address
   bts_line_mem u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && scan_info.in_row),
      .rd_addr (scan_info.addr),
      .rd_data (rd_data),
      .wr_en   (advance && s1_info_ff.in_row),
      .wr_addr (s1_info_ff.addr),
      .wr_data (wr_data),
      .busy    (clr_busy)
   );

   // window, decision and running count
   bts_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .info      (s1_info_ff),
      .rd_data   (rd_data),
      .direction (direction_ff),
      .pixel_out (dec_pixel),
      .deleted   (dec_deleted),
      .count     (dec_count),
      .wr_data   (wr_data)
   );

   // stage valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_info_ff.has_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= scan_info;
      end
      if (advance) begin
         rsp_pixel_ff   <= dec_pixel;
         rsp_deleted_ff <= dec_deleted;
         rsp_last_ff    <= s1_info_ff.last;
         rsp_count_ff   <= dec_count;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_out      = rsp_pixel_ff;
   assign rsp_deleted        = rsp_deleted_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_deletion_count = rsp_count_ff;

endmodule

`default_nettype wire

// ----- rtl/bts_scan.sv -----
// ----------------------------------------------------------------------------
// bts_scan
// raster position tracking: column, row and padding row detection
// ----------------------------------------------------------------------------
`default_nettype none

module bts_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic                              req_pixel,
   input  wire logic                              req_pad,
   input  wire logic [bts_pkg::WIDTH_W-1:0]       image_width,
   output bts_pkg::scan_info_type                 info
);

   logic [bts_pkg::COL_W-1:0] col_ff, col_in;
   logic [bts_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      row_pad_ff, row_pad_in;

   logic [31:0]               width_raw;
   logic [bts_pkg::COL_W-1:0] width_eff;
   logic [bts_pkg::COL_W-1:0] col_cl;
   logic                      row_pad_now;
   logic                      in_row;

   always_comb begin
      width_raw = 32'(image_width);
      if (width_raw == 32'd0) begin
         width_eff = bts_pkg::COL_W'(1);
      end else if (width_raw > 32'(bts_pkg::MAX_WIDTH)) begin
         width_eff = bts_pkg::COL_W'(bts_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_raw[bts_pkg::COL_W-1:0];
      end

      // a column past the width acts as the padding column
      col_cl = (col_ff > width_eff) ? width_eff : col_ff;
      in_row = (col_cl < width_eff);

      if (col_cl == '0) begin
         row_pad_now = req_pad || (32'(row_ff) >= 32'(bts_pkg::MAX_HEIGHT));
      end else begin
         row_pad_now = row_pad_ff;
      end

      info.bot       = in_row && !row_pad_now && !req_pad && req_pixel;
      info.in_row    = in_row;
      info.first_col = (col_cl == '0);
      info.has_rsp   = (row_ff != '0) && (col_cl != '0);
      info.last      = row_pad_now && (col_cl == width_eff);
      info.frame_end = row_pad_now && !in_row;
      info.mid_ok    = (row_ff != '0);
      info.top_ok    = (32'(row_ff) >= 32'd2);
      info.addr      = col_cl[bts_pkg::ADDR_W-1:0];

      col_in     = col_ff;
      row_in     = row_ff;
      row_pad_in = row_pad_ff;
      if (accept) begin
         row_pad_in = row_pad_now;
         if (!in_row) begin
            col_in = '0;
            if (row_pad_now) begin
               row_in     = '0;
               row_pad_in = 1'b0;
            end else if (32'(row_ff) < 32'(bts_pkg::MAX_HEIGHT)) begin
               row_in = row_ff + bts_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_cl + bts_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_pad_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_pad_ff <= row_pad_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bts_line_mem.sv -----
// ----------------------------------------------------------------------------
// bts_line_mem
// line store holding two earlier rows per column, cleared after reset
// ----------------------------------------------------------------------------
`default_nettype none

module bts_line_mem (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [bts_pkg::ADDR_W-1:0]   rd_addr,
   output logic      [1:0]                   rd_data,
   input  wire logic                         wr_en,
   input  wire logic [bts_pkg::ADDR_W-1:0]   wr_addr,
   input  wire logic [1:0]                   wr_data,
   output logic                              busy
);

   logic [1:0] mem [bts_pkg::MAX_WIDTH];

   logic                       clr_busy_ff, clr_busy_in;
   logic [bts_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]                 rd_data_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + bts_pkg::ADDR_W'(1);
         if (32'(clr_addr_ff) == bts_pkg::MAX_WIDTH - 1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 2'b00;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

// ----- rtl/bts_decide.sv -----
// ----------------------------------------------------------------------------
// bts_decide
// 3x3 window, deletion decision and saturating deletion count
// ----------------------------------------------------------------------------
`default_nettype none

module bts_decide (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire bts_pkg::scan_info_type       info,
   input  wire logic [1:0]                   rd_data,
   input  wire logic [bts_pkg::DIR_W-1:0]    direction,
   output logic                              pixel_out,
   output logic                              deleted,
   output logic      [bts_pkg::CNT_W-1:0]    count,
   output logic      [1:0]                   wr_data
);

   logic [bts_pkg::MAP_W-1:0] window_ff, window_in;
   logic [bts_pkg::CNT_W-1:0] total_ff, total_in;

   logic                      top, mid;
   logic [bts_pkg::MAP_W-1:0] column;
   logic                      center;
   logic                      del;

   always_comb begin
      mid    = info.in_row && info.mid_ok && rd_data[0];
      top    = info.in_row && info.top_ok && rd_data[1];
      column = {2'b00, top, 2'b00, mid, 2'b00, info.bot};

      if (info.first_col) begin
         window_in = column;
      end else begin
         window_in = ((window_ff << 1) & bts_pkg::SHIFT_MASK) | column;
      end

      center = window_in[4];
      del    = center && ((window_in & bts_pkg::DIR_MASK[direction]) == '0)
               && bts_pkg::DEL_TABLE[window_in];

      count = total_ff;
      if (del && (total_ff != bts_pkg::COUNT_MAX)) begin
         count = total_ff + bts_pkg::CNT_W'(1);
      end
      total_in = info.frame_end ? '0 : count;

      pixel_out = center && !del;
      deleted   = del;
      wr_data   = {mid, info.bot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         total_ff  <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         total_ff  <= total_in;
      end
   end

endmodule

`default_nettype wire
